/* hw/rtl/itaf_pkg.sv */
// itaf_pkg: shared constants, types and helpers for the integer to ascii formatter
// used by itaf_cell, itaf_ctrl and integer_to_ascii_formatter; no dependencies
`default_nettype none

package itaf_pkg;

	// width of a pointer value (32..64)
	localparam int VALUE_WIDTH = 64;

	localparam int DIGIT_W   = 4;
	localparam int DEC_CELLS = 10;
	localparam int PTR_CELLS = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
	localparam int NCELL     = (PTR_CELLS > DEC_CELLS) ? PTR_CELLS : DEC_CELLS;
	localparam int CELL_BITS = NCELL * DIGIT_W;
	localparam int REM_W     = $clog2(NCELL + 1);

	localparam int MAG_W     = 32;
	localparam int HEX32_CELLS = MAG_W / DIGIT_W;
	localparam int BITCNT_W  = $clog2(MAG_W + 1);

	localparam int CMD_W     = 3;
	localparam int IN_VAL_W  = 64;
	localparam int S_TDATA_W = ((CMD_W + IN_VAL_W + 7) / 8) * 8;

	localparam int CHAR_W    = 8;
	localparam int LEN_W     = 5;
	localparam int M_TDATA_W = ((CHAR_W + LEN_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_SDEC   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UDEC   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_HEX_LO = 3'd2;
	localparam logic [CMD_W-1:0] CMD_HEX_UP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PTR    = 3'd4;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

	typedef struct packed {
		logic load;
		logic conv;
		logic shift;
	} cell_ctl_t;

	function automatic logic [CHAR_W-1:0] ascii_digit(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? CH_UP_A : CH_LO_A;
		if (d < DIGIT_W'(10)) begin
			ascii_digit = CH_ZERO + CHAR_W'(d);
		end else begin
			ascii_digit = base + CHAR_W'(d) - CHAR_W'(10);
		end
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/itaf_cell.sv */
// itaf_cell: one digit cell of the conversion row
// double-dabble step, load, or shift toward the top; uses itaf_pkg
`default_nettype none

module itaf_cell (
	input  logic                          clk,
	input  itaf_pkg::cell_ctl_t           ctl,
	input  logic [itaf_pkg::DIGIT_W-1:0]  load_digit,
	input  logic [itaf_pkg::DIGIT_W-1:0]  nbr_digit,
	input  logic                          carry_in,
	output logic [itaf_pkg::DIGIT_W-1:0]  digit,
	output logic                          carry_out
);
	import itaf_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// add-3 correction before each shift of the bcd row
	always_comb begin
		adj = (digit_q >= DIGIT_W'(5)) ? (digit_q + DIGIT_W'(3)) : digit_q;
	end

	assign carry_out = ctl.conv & adj[DIGIT_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		priority if (ctl.load) begin
			digit_q <= load_digit;
		end else if (ctl.conv) begin
			digit_q <= {adj[DIGIT_W-2:0], carry_in};
		end else if (ctl.shift) begin
			digit_q <= nbr_digit;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/itaf_ctrl.sv */
// itaf_ctrl: command decode, sequencing of the digit row and output word register
// uses itaf_pkg; drives the itaf_cell row built in the top level
`default_nettype none

module itaf_ctrl (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	input  logic [itaf_pkg::S_TDATA_W-1:0]                s_tdata,
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	output logic [itaf_pkg::M_TDATA_W-1:0]                m_tdata,
	output logic                                          m_tlast,
	input  logic [itaf_pkg::DIGIT_W-1:0]                  top_digit,
	output itaf_pkg::cell_ctl_t                           cell_ctl,
	output logic [itaf_pkg::NCELL-1:0][itaf_pkg::DIGIT_W-1:0] load_dig,
	output logic                                          conv_bit
);
	import itaf_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SKIP, ST_EMIT} state_t;

	state_t               state_q;
	logic [MAG_W-1:0]     mag_q;
	logic [BITCNT_W-1:0]  bit_cnt_q;
	logic [REM_W-1:0]     rem_q;
	logic [1:0]           pre_q;
	logic                 ptr_q;
	logic                 upper_q;
	logic [LEN_W-1:0]     len_q;
	logic                 m_tvalid_q;
	logic                 last_q;
	logic [CHAR_W-1:0]    char_q;
	logic [LEN_W-1:0]     tot_q;

	logic [CMD_W-1:0]     cmd;
	logic [IN_VAL_W-1:0]  val;
	logic [MAG_W-1:0]     low32;
	logic [MAG_W-1:0]     abs32;
	logic [CELL_BITS-1:0] ptr_bits;
	logic                 accept;
	logic                 out_free;
	logic                 emit;
	logic                 skip_go;
	logic                 emit_last;
	logic [CHAR_W-1:0]    emit_char;

	assign cmd      = s_tdata[CMD_W-1:0];
	assign val      = s_tdata[CMD_W +: IN_VAL_W];
	assign low32    = val[MAG_W-1:0];
	assign abs32    = low32[MAG_W-1] ? (~low32 + MAG_W'(1)) : low32;
	assign ptr_bits = CELL_BITS'(val[VALUE_WIDTH-1:0]);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;
	assign emit     = (state_q == ST_EMIT) & out_free;
	assign skip_go  = (top_digit == '0) & (rem_q != REM_W'(1));
	assign emit_last = (pre_q == 2'd0) & (rem_q == REM_W'(1));

	always_comb begin
		if (pre_q != 2'd0) begin
			if (ptr_q) begin
				emit_char = (pre_q == 2'd2) ? CH_ZERO : CH_X;
			end else begin
				emit_char = CH_MINUS;
			end
		end else begin
			emit_char = ascii_digit(top_digit, upper_q);
		end
	end

	assign cell_ctl.load  = accept;
	assign cell_ctl.conv  = (state_q == ST_CONV);
	assign cell_ctl.shift = ((state_q == ST_SKIP) & skip_go) | (emit & (pre_q == 2'd0));
	assign conv_bit       = mag_q[MAG_W-1];

	// decimal starts from an empty row, hex digits go straight into the cells
	always_comb begin
		load_dig = '0;
		unique case (cmd)
			CMD_HEX_LO, CMD_HEX_UP: begin
				for (int k = 0; k < HEX32_CELLS; k++) begin
					load_dig[k] = low32[k*DIGIT_W +: DIGIT_W];
				end
			end
			CMD_PTR: begin
				for (int k = 0; k < NCELL; k++) begin
					load_dig[k] = ptr_bits[k*DIGIT_W +: DIGIT_W];
				end
			end
			default: begin
				load_dig = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mag_q      <= '0;
			bit_cnt_q  <= '0;
			rem_q      <= '0;
			pre_q      <= '0;
			ptr_q      <= 1'b0;
			upper_q    <= 1'b0;
			len_q      <= '0;
			m_tvalid_q <= 1'b0;
			last_q     <= 1'b0;
			char_q     <= '0;
			tot_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						len_q     <= '0;
						rem_q     <= REM_W'(NCELL);
						upper_q   <= (cmd == CMD_HEX_UP);
						bit_cnt_q <= BITCNT_W'(MAG_W);
						unique case (cmd)
							CMD_SDEC: begin
								mag_q   <= abs32;
								pre_q   <= low32[MAG_W-1] ? 2'd1 : 2'd0;
								ptr_q   <= 1'b0;
								state_q <= ST_CONV;
							end
							CMD_UDEC: begin
								mag_q   <= low32;
								pre_q   <= 2'd0;
								ptr_q   <= 1'b0;
								state_q <= ST_CONV;
							end
							CMD_HEX_LO, CMD_HEX_UP: begin
								pre_q   <= 2'd0;
								ptr_q   <= 1'b0;
								state_q <= ST_SKIP;
							end
							CMD_PTR: begin
								pre_q   <= 2'd2;
								ptr_q   <= 1'b1;
								state_q <= ST_SKIP;
							end
							default: begin
								// unused command: swallowed without output
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_CONV: begin
					mag_q     <= {mag_q[MAG_W-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q - BITCNT_W'(1);
					if (bit_cnt_q == BITCNT_W'(1)) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// drop leading zero digits, keep at least one
					if (skip_go) begin
						rem_q <= rem_q - REM_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						len_q <= len_q + LEN_W'(1);
						if (pre_q != 2'd0) begin
							pre_q <= pre_q - 2'd1;
						end else begin
							rem_q <= rem_q - REM_W'(1);
							if (rem_q == REM_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (emit) begin
				m_tvalid_q <= 1'b1;
				char_q     <= emit_char;
				last_q     <= emit_last;
				tot_q      <= emit_last ? (len_q + LEN_W'(1)) : '0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = M_TDATA_W'({tot_q, char_q});

endmodule

`default_nettype wire

/* hw/rtl/integer_to_ascii_formatter.sv */
// integer_to_ascii_formatter: top level, a row of digit cells and its sequencer
// uses itaf_pkg, itaf_cell and itaf_ctrl
`default_nettype none

// Prints one number per input word as ASCII text, one character per output
// word, most significant first, no leading zeros; command 0 signed decimal,
// 1 unsigned decimal, 2/3 lower/upper hex of the low 32 bits, 4 pointer hex
// with a 0x prefix. Digits live in a row of NCELL four-bit cells. Decimal
// runs a double-dabble pass through the row, one bit per cycle over the 32
// magnitude bits; hex loads the nibbles directly. The row then shifts up one
// cell per cycle past leading zero cells and settles on the leading digit,
// after which the characters leave one by one, held while the sink stalls.
// Leading zero cells plus digits always fill the row. A new word is taken
// once the final character is in the output register; commands 5 to 7
// produce nothing.
module integer_to_ascii_formatter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [itaf_pkg::S_TDATA_W-1:0] s_tdata,   // command[2:0], value[66:3], zero pad
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [itaf_pkg::M_TDATA_W-1:0] m_tdata,   // character[7:0], total_length[12:8], zero pad
	output logic                           m_tlast
);
	import itaf_pkg::*;

	cell_ctl_t                        cell_ctl;
	logic [NCELL-1:0][DIGIT_W-1:0]    load_dig;
	logic [NCELL-1:0][DIGIT_W-1:0]    dig;
	logic [NCELL-1:0]                 cout;
	logic                             conv_bit;

	itaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.top_digit (dig[NCELL-1]),
		.cell_ctl  (cell_ctl),
		.load_dig  (load_dig),
		.conv_bit  (conv_bit)
	);

	// cell 0 takes the next magnitude bit and a zero digit; others take their lower neighbor
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		if (i == 0) begin : g_first
			itaf_cell u_cell (
				.clk        (clk),
				.ctl        (cell_ctl),
				.load_digit (load_dig[i]),
				.nbr_digit  ('0),
				.carry_in   (conv_bit),
				.digit      (dig[i]),
				.carry_out  (cout[i])
			);
		end else begin : g_next
			itaf_cell u_cell (
				.clk        (clk),
				.ctl        (cell_ctl),
				.load_digit (load_dig[i]),
				.nbr_digit  (dig[i-1]),
				.carry_in   (cout[i-1]),
				.digit      (dig[i]),
				.carry_out  (cout[i])
			);
		end
	end

endmodule

`default_nettype wire

/* dv/integer_to_ascii_formatter_test.sv */
`timescale 1ns / 1ps
// integer_to_ascii_formatter_test: self-checking bench for the integer to ascii formatter
// drives numbers with random gaps, predicts the text and checks each output word; uses itaf_pkg

module integer_to_ascii_formatter_test;
	import itaf_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
	localparam logic [63:0] PTR_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);
	localparam int MAX_CHARS = 18;
	localparam int RANDOM_NUMBERS = 425;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [63:0]      value;
	} number_item_t;

	typedef struct {
		logic [CHAR_W-1:0] character;
		logic              last_char;
		logic [LEN_W-1:0]  total_length;
	} text_char_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;   // command[2:0], value[66:3], zero pad
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // character[7:0], total_length[12:8], zero pad
	logic                 m_tlast;

	number_item_t number_q[$];
	text_char_t   pending_chars[$];
	int           mismatches = 0;
	int           send_gap = 0;
	int           stall_left = 0;
	bit           send_burst = 1'b0;
	bit           recv_burst = 1'b0;

	integer_to_ascii_formatter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// expected text of one number, queued one character per word
	function automatic void format_number(input logic [CMD_W-1:0] cmd,
			input logic [63:0] value);
		logic [63:0]       mag;
		logic [63:0]       base;
		logic [3:0]        digit;
		logic [CHAR_W-1:0] letter_a;
		logic [CHAR_W-1:0] text[$];
		int                start;
		text_char_t        c;
		base = 64'd16;
		letter_a = CH_LO_A;
		mag = {32'd0, value[31:0]};
		case (cmd)
			CMD_SDEC: begin
				base = 64'd10;
				// negate in 32 bits so the most negative value keeps its magnitude
				if (value[31]) begin
					text.push_back(CH_MINUS);
					mag = {32'd0, ~value[31:0] + 32'd1};
				end
			end
			CMD_UDEC: base = 64'd10;
			CMD_HEX_LO: letter_a = CH_LO_A;
			CMD_HEX_UP: letter_a = CH_UP_A;
			CMD_PTR: begin
				text.push_back(CH_ZERO);
				text.push_back(CH_X);
				mag = value & PTR_MASK;
			end
			default: return;
		endcase
		start = text.size();
		do begin
			digit = 4'(mag % base);
			text.insert(start, (digit < 4'd10) ? CH_ZERO + CHAR_W'(digit)
				: letter_a + CHAR_W'(digit) - CHAR_W'(10));
			mag = mag / base;
		end while (mag != 0);
		if (text.size() > MAX_CHARS)
			text = text[0:MAX_CHARS-1];
		foreach (text[k]) begin
			c.character = text[k];
			c.last_char = (k == text.size() - 1);
			c.total_length = c.last_char ? LEN_W'(text.size()) : '0;
			pending_chars.push_back(c);
		end
	endfunction

	task automatic add_number(input logic [CMD_W-1:0] cmd, input logic [63:0] value);
		number_item_t n;
		n.cmd = cmd;
		n.value = value;
		number_q.push_back(n);
	endtask

	// source side: offers queued numbers, random gap after each accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				format_number(s_tdata[CMD_W-1:0], s_tdata[CMD_W+63:CMD_W]);
				void'(number_q.pop_front());
				if ($urandom_range(0, 29) == 0)
					send_burst = !send_burst;
				send_gap = send_burst ? 0 : $urandom_range(0, 19);
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (number_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {{(S_TDATA_W - CMD_W - 64){1'b0}}, number_q[0].value,
						number_q[0].cmd};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side: checks each accepted word, random stall after each one
	always @(posedge clk or negedge arst_n) begin
		text_char_t exp_c;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_chars.size() == 0) begin
					$error("unexpected word: character %h last %b length %0d",
						m_tdata[7:0], m_tlast, m_tdata[12:8]);
					mismatches++;
				end else begin
					exp_c = pending_chars.pop_front();
					if (m_tdata[7:0] !== exp_c.character) begin
						$error("character: expected %h, got %h", exp_c.character, m_tdata[7:0]);
						mismatches++;
					end
					if (m_tlast !== exp_c.last_char) begin
						$error("last_char: expected %b, got %b", exp_c.last_char, m_tlast);
						mismatches++;
					end
					if (m_tdata[12:8] !== exp_c.total_length) begin
						$error("total_length: expected %0d, got %0d", exp_c.total_length,
							m_tdata[12:8]);
						mismatches++;
					end
				end
				if ($urandom_range(0, 29) == 0)
					recv_burst = !recv_burst;
				stall_left = recv_burst ? 0 : $urandom_range(0, 19);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int               counted;
		logic [CMD_W-1:0] cmd;
		logic [63:0]      value;
		logic [31:0]      near;
		// signed decimal: zero, one, minus one, both extremes, upper bits ignored; then unsigned and hex cases
		add_number(CMD_SDEC, 64'd0);
		add_number(CMD_SDEC, 64'd1);
		add_number(CMD_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
		add_number(CMD_SDEC, 64'h0000_0000_7FFF_FFFF);
		add_number(CMD_SDEC, 64'h0000_0000_8000_0000);
		add_number(CMD_SDEC, 64'hA5A5_A5A5_8000_0000);
		add_number(CMD_UDEC, 64'd0);
		add_number(CMD_UDEC, 64'h0000_0000_FFFF_FFFF);
		add_number(CMD_UDEC, 64'hFFFF_FFFF_0000_0000);
		add_number(CMD_HEX_LO, 64'd0);
		add_number(CMD_HEX_LO, 64'h0000_0000_89AB_CDEF);
		add_number(CMD_HEX_LO, 64'h1234_5678_FFFF_FFFF);
		add_number(CMD_HEX_UP, 64'd0);
		add_number(CMD_HEX_UP, 64'hDEAD_0000_FEDC_BA98);
		// pointer: zero prints 0x0, full width, a single digit, top bit alone
		add_number(CMD_PTR, 64'd0);
		add_number(CMD_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
		add_number(CMD_PTR, 64'd1);
		add_number(CMD_PTR, 64'h0123_4567_89AB_CDEF);
		add_number(CMD_PTR, 64'h8000_0000_0000_0000);
		// unused commands print nothing
		add_number(CMD_RSVD_FIRST, {$urandom, $urandom});
		add_number(CMD_RSVD_FIRST + 3'd1, {$urandom, $urandom});
		add_number(CMD_RSVD_FIRST + 3'd2, 64'hFFFF_FFFF_FFFF_FFFF);

		counted = 0;
		while (counted < RANDOM_NUMBERS) begin
			if ($urandom_range(0, 19) == 0) begin
				add_number(CMD_RSVD_FIRST + 3'($urandom_range(0, 2)), {$urandom, $urandom});
				continue;
			end
			cmd = 3'($urandom_range(0, 4));
			case ($urandom_range(0, 3))
				0: value = {$urandom, $urandom};
				1: value = {$urandom, $urandom} >> $urandom_range(0, 63);
				2: value = {$urandom, $urandom >> $urandom_range(0, 31)};
				default: begin
					// close to the signed and unsigned extremes
					near = 32'($urandom_range(0, 15));
					value = {$urandom, ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF - near
						: 32'h8000_0000 + near - 32'd8};
				end
			endcase
			add_number(cmd, value);
			counted++;
		end

		wait (arst_n === 1'b1);
		do
			@(negedge clk);
		while (number_q.size() != 0 || s_tvalid || pending_chars.size() != 0);
		repeat (80) @(negedge clk);
		if (mismatches == 0) begin
			$display("integer_to_ascii_formatter verification clean");
		end else begin
			$display("integer_to_ascii_formatter verification failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("integer_to_ascii_formatter verification failed");
		$finish;
	end

endmodule
